/* rtl/core/pearson_correlation_stream_assert.svh */
// assertion macros for the pearson correlation stream
`ifndef PEARSON_CORRELATION_STREAM_ASSERT_SVH
`define PEARSON_CORRELATION_STREAM_ASSERT_SVH

// same-cycle implication, checked outside reset
`define PCS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define PCS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/pcs_pkg.sv */
// shared types and constants of the pearson correlation stream
package pcs_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int CORR_W      = 16;
    localparam int USED_W      = 13;
    localparam int WIDE_W      = 64;
    localparam int QUEUE_DEPTH = 4;
    localparam int STATE_W     = 3;
    localparam int JOB_W       = 3;
    localparam int STEP_W      = 5;

    localparam logic [STATE_W-1:0] ST_IDLE = 3'd0;
    localparam logic [STATE_W-1:0] ST_MUL  = 3'd1;
    localparam logic [STATE_W-1:0] ST_DIV  = 3'd2;
    localparam logic [STATE_W-1:0] ST_SQRT = 3'd3;
    localparam logic [STATE_W-1:0] ST_DONE = 3'd4;

    localparam logic [JOB_W-1:0] JOB_N_XY  = 3'd0;
    localparam logic [JOB_W-1:0] JOB_X_Y   = 3'd1;
    localparam logic [JOB_W-1:0] JOB_N_XX  = 3'd2;
    localparam logic [JOB_W-1:0] JOB_X_X   = 3'd3;
    localparam logic [JOB_W-1:0] JOB_N_YY  = 3'd4;
    localparam logic [JOB_W-1:0] JOB_Y_Y   = 3'd5;
    localparam logic [JOB_W-1:0] JOB_MAG2  = 3'd6;
    localparam logic [JOB_W-1:0] JOB_VAR2  = 3'd7;

    localparam logic [STEP_W-1:0] MUL_LAST  = 5'd4;
    localparam logic [STEP_W-1:0] DIV_LAST  = 5'd31;
    localparam logic [STEP_W-1:0] SQRT_LAST = 5'd15;

    localparam logic [CORR_W-1:0] CORR_POS_MAX = 16'h7FFF;

    typedef struct packed {
        logic empty;
        logic nearly_full;
    } qstat_t;

endpackage

/* rtl/core/pearson_correlation_stream.sv */
// Pearson correlation of (x, y) sample series, top level. Each pushed beat
// carries one pair and is taken back to back, while full is low, by the front
// end, which squares and folds it into a count and five exact sums; pairs past
// MAX_SAMPLES are dropped and flagged. A beat marked last closes the series and
// hands its sums to a four-deep queue. The back end works one series at a time
// on a single 32x32 multiplier (eight 64-bit products), then a bit-serial divide
// and square root. The divide is skipped when the coefficient has magnitude
// exactly one, and the last two products, the divide and the root are skipped
// when the spread is zero. full rises while three closed series wait in the
// queue; one finished result waits in the output register.
`include "pearson_correlation_stream_assert.svh"

module pearson_correlation_stream #(
    parameter int MAX_SAMPLES  = 4096
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic signed [pcs_pkg::SAMPLE_W-1:0] x_sample,
    input  logic signed [pcs_pkg::SAMPLE_W-1:0] y_sample,
    input  logic                              last_sample,
    output logic                              empty,
    input  logic                              pop,
    output logic signed [pcs_pkg::CORR_W-1:0] correlation,
    output logic                              zero_spread,
    output logic                              overflowed,
    output logic [pcs_pkg::USED_W-1:0]        samples_used
);

    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W = pcs_pkg::SAMPLE_W + CNT_W;
    localparam int SQ_W  = 2 * pcs_pkg::SAMPLE_W + CNT_W;
    localparam int REC_W = 1 + CNT_W + 2 * SUM_W + 3 * SQ_W;

    logic             accept;
    logic             rec_push, rec_pop;
    logic [REC_W-1:0] rec_in, rec_out;
    pcs_pkg::qstat_t  qstat;

    assign full   = qstat.nearly_full;
    assign accept = push && !full;

    pcs_front #(
        .MAX_SAMPLES  (MAX_SAMPLES),
        .SAMPLE_WIDTH (pcs_pkg::SAMPLE_W),
        .CNT_W        (CNT_W),
        .SUM_W        (SUM_W),
        .SQ_W         (SQ_W),
        .REC_W        (REC_W)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .x_sample    (x_sample),
        .y_sample    (y_sample),
        .last_sample (last_sample),
        .rec_push    (rec_push),
        .rec_data    (rec_in)
    );

    pcs_queue #(
        .W     (REC_W),
        .DEPTH (pcs_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (rec_push),
        .push_data (rec_in),
        .pop       (rec_pop),
        .pop_data  (rec_out),
        .stat      (qstat)
    );

    pcs_back #(
        .CNT_W (CNT_W),
        .SUM_W (SUM_W),
        .SQ_W  (SQ_W),
        .REC_W (REC_W)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .qstat        (qstat),
        .rec_data     (rec_out),
        .rec_pop      (rec_pop),
        .pop          (pop),
        .empty        (empty),
        .correlation  (correlation),
        .zero_spread  (zero_spread),
        .overflowed   (overflowed),
        .samples_used (samples_used)
    );

    `PCS_ASSERT_IMPL(a_zero_spread_gives_zero, !empty && zero_spread, correlation == '0, "zero spread")
    `PCS_ASSERT_IMPL(a_overflow_count, !empty && overflowed, samples_used == pcs_pkg::USED_W'(MAX_SAMPLES), "short count")
    `PCS_ASSERT_IMPL(a_full_has_work, full, !qstat.empty, "full with no series queued")
    `PCS_ASSERT_NEXT(a_result_held, !empty && !pop, !empty && $stable(correlation), "result lost")

endmodule

/* rtl/core/pcs_queue.sv */
// series record queue between the accumulating front and the computing back
module pcs_queue #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  logic [W-1:0]   push_data,
    input  logic           pop,
    output logic [W-1:0]   pop_data,
    output pcs_pkg::qstat_t stat
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [W-1:0]     pop_data_reg;
    logic             do_pop;

    assign do_pop = pop && (count_reg != '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // popped record appears the cycle after the pop
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
        if (do_pop)
        begin
            pop_data_reg <= mem[rd_ptr_reg];
        end
    end

    assign pop_data         = pop_data_reg;
    assign stat.empty       = (count_reg == '0);
    assign stat.nearly_full = (count_reg >= CNT_W'(DEPTH - 1));

endmodule

/* rtl/core/pcs_front.sv */
// front end: takes sample beats, counts, squares and accumulates the five sums
module pcs_front #(
    parameter int MAX_SAMPLES  = 4096,
    parameter int SAMPLE_WIDTH = 16,
    parameter int CNT_W        = 13,
    parameter int SUM_W        = 29,
    parameter int SQ_W         = 45,
    parameter int REC_W        = 1
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           accept,
    input  logic signed [SAMPLE_WIDTH-1:0] x_sample,
    input  logic signed [SAMPLE_WIDTH-1:0] y_sample,
    input  logic                           last_sample,
    output logic                           rec_push,
    output logic [REC_W-1:0]               rec_data
);

    localparam int PROD_W = 2 * SAMPLE_WIDTH;

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             drop_reg, drop_next;
    logic             keep;
    logic [CNT_W-1:0] n_final;

    logic                           s1_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] s1_x_reg, s1_y_reg;
    logic signed [PROD_W-1:0]       s1_xy_reg, s1_xx_reg, s1_yy_reg;
    logic                           s1_keep_reg, s1_last_reg, s1_drop_reg;
    logic [CNT_W-1:0]               s1_n_reg;

    logic signed [SUM_W-1:0] sx_reg, sy_reg, sx_add, sy_add;
    logic signed [SQ_W-1:0]  sxy_reg, sxx_reg, syy_reg, sxy_add, sxx_add, syy_add;

    assign keep    = (cnt_reg != CNT_W'(MAX_SAMPLES));
    assign n_final = keep ? cnt_reg + 1'b1 : cnt_reg;

    always_comb
    begin
        cnt_next  = cnt_reg;
        drop_next = drop_reg;
        if (accept)
        begin
            if (last_sample)
            begin
                cnt_next  = '0;
                drop_next = 1'b0;
            end
            else
            begin
                cnt_next  = n_final;
                drop_next = drop_reg | !keep;
            end
        end
    end

    // stage two: fold the registered samples and products into the sums
    assign sx_add  = s1_keep_reg ? sx_reg + SUM_W'(s1_x_reg) : sx_reg;
    assign sy_add  = s1_keep_reg ? sy_reg + SUM_W'(s1_y_reg) : sy_reg;
    assign sxy_add = s1_keep_reg ? sxy_reg + SQ_W'(s1_xy_reg) : sxy_reg;
    assign sxx_add = s1_keep_reg ? sxx_reg + SQ_W'(s1_xx_reg) : sxx_reg;
    assign syy_add = s1_keep_reg ? syy_reg + SQ_W'(s1_yy_reg) : syy_reg;

    assign rec_push = s1_valid_reg && s1_last_reg;
    assign rec_data = {s1_drop_reg, s1_n_reg, sx_add, sy_add, sxy_add, sxx_add, syy_add};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            drop_reg     <= 1'b0;
            s1_valid_reg <= 1'b0;
            sx_reg       <= '0;
            sy_reg       <= '0;
            sxy_reg      <= '0;
            sxx_reg      <= '0;
            syy_reg      <= '0;
        end
        else
        begin
            cnt_reg      <= cnt_next;
            drop_reg     <= drop_next;
            s1_valid_reg <= accept;
            if (s1_valid_reg)
            begin
                if (s1_last_reg)
                begin
                    sx_reg  <= '0;
                    sy_reg  <= '0;
                    sxy_reg <= '0;
                    sxx_reg <= '0;
                    syy_reg <= '0;
                end
                else
                begin
                    sx_reg  <= sx_add;
                    sy_reg  <= sy_add;
                    sxy_reg <= sxy_add;
                    sxx_reg <= sxx_add;
                    syy_reg <= syy_add;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_x_reg    <= x_sample;
            s1_y_reg    <= y_sample;
            s1_xy_reg   <= x_sample * y_sample;
            s1_xx_reg   <= x_sample * x_sample;
            s1_yy_reg   <= y_sample * y_sample;
            s1_keep_reg <= keep;
            s1_last_reg <= last_sample;
            s1_n_reg    <= n_final;
            s1_drop_reg <= drop_reg | !keep;
        end
    end

endmodule

/* rtl/core/pcs_back.sv */
// back end: covariance terms, exact rounded ratio by divide and root, result register
module pcs_back #(
    parameter int CNT_W = 13,
    parameter int SUM_W = 29,
    parameter int SQ_W  = 45,
    parameter int REC_W = 1
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  pcs_pkg::qstat_t            qstat,
    input  logic [REC_W-1:0]           rec_data,
    output logic                       rec_pop,
    input  logic                       pop,
    output logic                       empty,
    output logic signed [pcs_pkg::CORR_W-1:0] correlation,
    output logic                       zero_spread,
    output logic                       overflowed,
    output logic [pcs_pkg::USED_W-1:0] samples_used
);

    localparam int W   = pcs_pkg::WIDE_W;
    localparam int W2  = 2 * pcs_pkg::WIDE_W;
    localparam int OFF_SYY = 0;
    localparam int OFF_SXX = OFF_SYY + SQ_W;
    localparam int OFF_SXY = OFF_SXX + SQ_W;
    localparam int OFF_SY  = OFF_SXY + SQ_W;
    localparam int OFF_SX  = OFF_SY + SUM_W;
    localparam int OFF_N   = OFF_SX + SUM_W;
    localparam int OFF_DRP = OFF_N + CNT_W;

    logic [pcs_pkg::STATE_W-1:0] state_reg, state_next;
    logic [pcs_pkg::JOB_W-1:0]   job_reg, job_next;
    logic [pcs_pkg::STEP_W-1:0]  step_reg, step_next;
    logic                        out_valid_reg, out_valid_next;
    logic                        ld_reg;
    logic                        load_out;
    logic                        pop_ok;

    logic [W-1:0]  n_reg, sx_reg, sy_reg, sxy_reg, sxx_reg, syy_reg;
    logic          drop_reg;
    logic [W-1:0]  t_reg, num_reg, va_reg, vb_reg;
    logic [W2-1:0] m2_reg, p_reg, rem_reg, acc_reg;
    logic [W-1:0]  mul_reg;
    logic [1:0]    mul_part_reg;
    logic [31:0]   q_reg;
    logic [16:0]   srem_reg;
    logic [15:0]   root_reg;
    logic          zs_reg;

    logic [W-1:0]  op_a, op_b, mag, low, diff;
    logic [31:0]   a_part, b_part;
    logic [1:0]    part;
    logic [W2-1:0] shifted, acc_new;
    logic [W2:0]   div_r2;
    logic          div_ge;
    logic [18:0]   sq_sh, sq_trial;
    logic          sq_ge;
    logic [16:0]   k_val;
    logic [pcs_pkg::CORR_W-1:0] corr_calc;

    logic signed [pcs_pkg::CORR_W-1:0] corr_out_reg;
    logic                              zs_out_reg, drop_out_reg;
    logic [pcs_pkg::USED_W-1:0]        used_out_reg;

    assign pop_ok   = pop && out_valid_reg;
    assign load_out = (state_reg == pcs_pkg::ST_DONE) && (!out_valid_reg || pop);
    assign rec_pop  = (state_reg == pcs_pkg::ST_IDLE) && !qstat.empty;

    assign mag  = num_reg[W-1] ? (~num_reg + 1'b1) : num_reg;
    assign part = step_reg[1:0];

    always_comb
    begin
        unique case (job_reg)
            pcs_pkg::JOB_N_XY: begin op_a = n_reg;   op_b = sxy_reg; end
            pcs_pkg::JOB_X_Y:  begin op_a = sx_reg;  op_b = sy_reg;  end
            pcs_pkg::JOB_N_XX: begin op_a = n_reg;   op_b = sxx_reg; end
            pcs_pkg::JOB_X_X:  begin op_a = sx_reg;  op_b = sx_reg;  end
            pcs_pkg::JOB_N_YY: begin op_a = n_reg;   op_b = syy_reg; end
            pcs_pkg::JOB_Y_Y:  begin op_a = sy_reg;  op_b = sy_reg;  end
            pcs_pkg::JOB_MAG2: begin op_a = mag;     op_b = mag;     end
            pcs_pkg::JOB_VAR2: begin op_a = va_reg;  op_b = vb_reg;  end
            default:           begin op_a = '0;      op_b = '0;      end
        endcase
    end

    assign a_part = part[1] ? op_a[63:32] : op_a[31:0];
    assign b_part = part[0] ? op_b[63:32] : op_b[31:0];

    always_comb
    begin
        unique case (mul_part_reg)
            2'd0:    shifted = {64'd0, mul_reg};
            2'd1:    shifted = {32'd0, mul_reg, 32'd0};
            2'd2:    shifted = {32'd0, mul_reg, 32'd0};
            default: shifted = {mul_reg, 64'd0};
        endcase
    end

    assign acc_new = (step_reg == '0) ? '0 : acc_reg + shifted;
    assign low     = acc_new[W-1:0];
    assign diff    = t_reg - low;

    // one quotient bit of (mag^2 * 2^32) / (va * vb)
    assign div_r2 = {rem_reg, 1'b0};
    assign div_ge = (div_r2 >= {1'b0, p_reg});

    // one root bit of the quotient
    assign sq_sh    = {srem_reg, q_reg[31:30]};
    assign sq_trial = {1'b0, root_reg, 2'b01};
    assign sq_ge    = (sq_sh >= sq_trial);

    assign k_val = ({1'b0, root_reg} + 17'd1) >> 1;

    always_comb
    begin
        if (zs_reg)
        begin
            corr_calc = '0;
        end
        else if (num_reg[W-1])
        begin
            corr_calc = 16'(17'd0 - k_val);
        end
        else if (k_val > 17'(pcs_pkg::CORR_POS_MAX))
        begin
            corr_calc = pcs_pkg::CORR_POS_MAX;
        end
        else
        begin
            corr_calc = k_val[15:0];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        job_next       = job_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        if (pop_ok)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            pcs_pkg::ST_IDLE:
            begin
                if (!qstat.empty)
                begin
                    state_next = pcs_pkg::ST_MUL;
                    job_next   = pcs_pkg::JOB_N_XY;
                    step_next  = '0;
                end
            end
            pcs_pkg::ST_MUL:
            begin
                // first cycle waits for the popped record to land
                if (ld_reg)
                begin
                    step_next = step_reg;
                end
                else if (step_reg == pcs_pkg::MUL_LAST)
                begin
                    step_next = '0;
                    job_next  = job_reg + 1'b1;
                    if (job_reg == pcs_pkg::JOB_Y_Y)
                    begin
                        if ($signed(va_reg) <= 0 || $signed(diff) <= 0)
                        begin
                            state_next = pcs_pkg::ST_DONE;
                        end
                    end
                    else if (job_reg == pcs_pkg::JOB_VAR2)
                    begin
                        state_next = (m2_reg >= acc_new) ? pcs_pkg::ST_SQRT : pcs_pkg::ST_DIV;
                    end
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            pcs_pkg::ST_DIV:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == pcs_pkg::DIV_LAST)
                begin
                    state_next = pcs_pkg::ST_SQRT;
                    step_next  = '0;
                end
            end
            pcs_pkg::ST_SQRT:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == pcs_pkg::SQRT_LAST)
                begin
                    state_next = pcs_pkg::ST_DONE;
                    step_next  = '0;
                end
            end
            pcs_pkg::ST_DONE:
            begin
                if (load_out)
                begin
                    state_next     = pcs_pkg::ST_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = pcs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pcs_pkg::ST_IDLE;
            job_reg       <= pcs_pkg::JOB_N_XY;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            ld_reg        <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            job_reg       <= job_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            ld_reg        <= rec_pop;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld_reg)
        begin
            n_reg    <= W'(rec_data[OFF_N +: CNT_W]);
            sx_reg   <= W'(signed'(rec_data[OFF_SX +: SUM_W]));
            sy_reg   <= W'(signed'(rec_data[OFF_SY +: SUM_W]));
            sxy_reg  <= W'(signed'(rec_data[OFF_SXY +: SQ_W]));
            sxx_reg  <= W'(signed'(rec_data[OFF_SXX +: SQ_W]));
            syy_reg  <= W'(signed'(rec_data[OFF_SYY +: SQ_W]));
            drop_reg <= rec_data[OFF_DRP];
        end
        if (state_reg == pcs_pkg::ST_MUL)
        begin
            if (step_reg != pcs_pkg::MUL_LAST)
            begin
                mul_reg      <= a_part * b_part;
                mul_part_reg <= part;
            end
            acc_reg <= acc_new;
            if (step_reg == pcs_pkg::MUL_LAST)
            begin
                unique case (job_reg)
                    pcs_pkg::JOB_N_XY: t_reg   <= low;
                    pcs_pkg::JOB_X_Y:  num_reg <= diff;
                    pcs_pkg::JOB_N_XX: t_reg   <= low;
                    pcs_pkg::JOB_X_X:  va_reg  <= diff;
                    pcs_pkg::JOB_N_YY: t_reg   <= low;
                    pcs_pkg::JOB_Y_Y:
                    begin
                        vb_reg <= diff;
                        zs_reg <= ($signed(va_reg) <= 0 || $signed(diff) <= 0);
                    end
                    pcs_pkg::JOB_MAG2: m2_reg  <= acc_new;
                    default:
                    begin
                        p_reg    <= acc_new;
                        rem_reg  <= m2_reg;
                        q_reg    <= (m2_reg >= acc_new) ? '1 : '0;
                        srem_reg <= '0;
                        root_reg <= '0;
                    end
                endcase
            end
        end
        if (state_reg == pcs_pkg::ST_DIV)
        begin
            rem_reg <= div_ge ? W2'(div_r2 - {1'b0, p_reg}) : div_r2[W2-1:0];
            q_reg   <= {q_reg[30:0], div_ge};
        end
        if (state_reg == pcs_pkg::ST_SQRT)
        begin
            srem_reg <= sq_ge ? 17'(sq_sh - sq_trial) : sq_sh[16:0];
            root_reg <= {root_reg[14:0], sq_ge};
            q_reg    <= {q_reg[29:0], 2'b00};
        end
        if (load_out)
        begin
            corr_out_reg <= corr_calc;
            zs_out_reg   <= zs_reg;
            drop_out_reg <= drop_reg;
            used_out_reg <= pcs_pkg::USED_W'(n_reg);
        end
    end

    assign empty        = !out_valid_reg;
    assign correlation  = corr_out_reg;
    assign zero_spread  = zs_out_reg;
    assign overflowed   = drop_out_reg;
    assign samples_used = used_out_reg;

endmodule
